>>> hdl/kbcc_pkg.sv
// ----------------------------------------------------------------------------
// kbcc_pkg
// Shared types, constants and functions of the key base32 checksum encoder.
// ----------------------------------------------------------------------------
package kbcc_pkg;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W      = PTR_W + 1;
	localparam int unsigned DATA_W     = 35;

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [6:0]  CHR_A    = 7'd65;
	localparam logic [6:0]  CHR_2M26 = 7'd24;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic [2:0]        nchars;
		logic              last;
	} kbcc_entry_t;

	typedef struct packed {
		logic        valid;
		kbcc_entry_t entry;
	} kbcc_push_t;

	// CRC of one byte from a zero register, MSB first
	function automatic logic [15:0] crc_byte(input logic [7:0] b);
		logic [15:0] c;
		c = {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

	function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
		return {crc[7:0], 8'h00} ^ crc_byte(crc[15:8] ^ b);
	endfunction

	function automatic logic [6:0] to_char(input logic [4:0] v);
		if (v < 5'd26) begin
			return {2'b00, v} + CHR_A;
		end else begin
			return {2'b00, v} + CHR_2M26;
		end
	endfunction

endpackage

>>> hdl/kbcc_front.sv
// ----------------------------------------------------------------------------
// kbcc_front
// Accepts byte beats, runs the CRC, packs held bits and bytes into one
// character group per beat.
// ----------------------------------------------------------------------------
module kbcc_front import kbcc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] lead_byte,
	input  logic [7:0] payload_byte,
	input  logic       start_req,
	input  logic       final_req,
	output kbcc_push_t push
);

	logic [15:0] crc_q;
	logic [3:0]  held_q;
	logic [2:0]  hc_q;

	logic [15:0] crc_base, crc_new;
	logic [3:0]  held_eff, held_n, held_mask;
	logic [2:0]  hc_eff, q, rem;
	logic [31:0] bytes;
	logic [2:0]  nb;
	logic [5:0]  total, five_q;
	logic [9:0]  prod;
	logic [35:0] stream, right;

	always_comb begin
		hc_eff   = start_req ? 3'd0 : hc_q;
		held_eff = start_req ? 4'd0 : held_q;
		crc_base = start_req ? crc_byte(lead_byte) : crc_q;
		crc_new  = crc_add(crc_base, payload_byte);

		case ({start_req, final_req})
			2'b11: begin
				bytes = {lead_byte, payload_byte, crc_new[7:0], crc_new[15:8]};
				nb    = 3'd4;
			end
			2'b10: begin
				bytes = {lead_byte, payload_byte, 16'h0000};
				nb    = 3'd2;
			end
			2'b01: begin
				bytes = {payload_byte, crc_new[7:0], crc_new[15:8], 8'h00};
				nb    = 3'd3;
			end
			default: begin
				bytes = {payload_byte, 24'h000000};
				nb    = 3'd1;
			end
		endcase

		total  = {3'b000, hc_eff} + {nb, 3'b000};
		prod   = {4'b0000, total} * 10'd13;
		q      = prod[8:6];
		five_q = {1'b0, q, 2'b00} + {3'b000, q};
		rem    = 3'(total - five_q);

		stream = ({held_eff, 32'h0} << (3'd4 - hc_eff)) | ({bytes, 4'h0} >> hc_eff);
		right     = stream >> (6'd36 - total);
		held_mask = ~(4'hF << rem);
		held_n    = right[3:0] & held_mask;

		push.valid        = accept;
		push.entry.data   = stream[35:1];
		push.entry.nchars = (final_req && rem != 3'd0) ? q + 3'd1 : q;
		push.entry.last   = final_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= '0;
			held_q <= '0;
			hc_q   <= '0;
		end else if (accept) begin
			if (final_req) begin
				crc_q  <= '0;
				held_q <= '0;
				hc_q   <= '0;
			end else begin
				crc_q  <= crc_new;
				held_q <= held_n;
				hc_q   <= rem;
			end
		end
	end

endmodule

>>> hdl/kbcc_fifo.sv
// ----------------------------------------------------------------------------
// kbcc_fifo
// Short queue of character groups between front and back.
// ----------------------------------------------------------------------------
module kbcc_fifo import kbcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  kbcc_push_t  push,
	input  logic        pop,
	output kbcc_entry_t head,
	output logic        empty,
	output logic        full
);

	kbcc_entry_t      mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CNT_W'(FIFO_DEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push.valid, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> hdl/kbcc_back.sv
// ----------------------------------------------------------------------------
// kbcc_back
// Walks the head group one character per cycle, while out_stall is low, into the output register.
// ----------------------------------------------------------------------------
module kbcc_back import kbcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  kbcc_entry_t head,
	input  logic        empty,
	output logic        pop,
	input  logic        out_stall,
	output logic        out_valid,
	output logic [6:0]  out_char,
	output logic        end_of_text
);

	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [6:0] out_char_q;
	logic       eot_q;

	logic       advance, last_char;
	logic [4:0] sym;

	always_comb begin
		advance   = !out_valid_q || !out_stall;
		last_char = (idx_q == head.nchars - 3'd1);
		pop       = advance && !empty && last_char;
		case (idx_q)
			3'd0:    sym = head.data[34:30];
			3'd1:    sym = head.data[29:25];
			3'd2:    sym = head.data[24:20];
			3'd3:    sym = head.data[19:15];
			3'd4:    sym = head.data[14:10];
			3'd5:    sym = head.data[9:5];
			3'd6:    sym = head.data[4:0];
			default: sym = 5'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= !empty;
			if (!empty) begin
				idx_q <= last_char ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && !empty) begin
			out_char_q <= to_char(sym);
			eot_q      <= head.last && last_char;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_char    = out_char_q;
	assign end_of_text = eot_q;

endmodule

>>> hdl/key_base32_checksum_encoder_core.sv
// ----------------------------------------------------------------------------
// key_base32_checksum_encoder_core
// Streams a key record as base32 text with a trailing CRC-16 checksum.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): one payload byte per beat. start_req
// marks the first byte and brings lead_byte in ahead of it; final_req
// marks the last byte and appends the CRC low and high bytes, then flushes
// the leftover bits zero-filled. end_of_text flags the last character.
// Output channel (out_valid/out_stall): one ASCII character per beat.
// A byte accepted is written into the group queue; its first character then
// leaves through the output register. Each byte gives 1 to 7 characters,
// one per cycle while out_stall is low; the single-character output
// register sets that rate. The front takes a byte every cycle while the
// four-entry group queue has room; in_stall is high when the queue is full.
// A stall on the output holds the character and fills the queue, which then
// raises in_stall. Reset clears the CRC, the held bits, the queue and the
// output valid flag; the first record may start at once.
// ----------------------------------------------------------------------------
module key_base32_checksum_encoder_core import kbcc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] lead_byte,
	input  logic [7:0] payload_byte,
	input  logic       start_req,
	input  logic       final_req,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [6:0] out_char,
	output logic       end_of_text
);

	kbcc_push_t  push;
	kbcc_entry_t head;
	logic        empty, full, pop, accept;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	kbcc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.lead_byte    (lead_byte),
		.payload_byte (payload_byte),
		.start_req    (start_req),
		.final_req    (final_req),
		.push         (push)
	);

	kbcc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.empty  (empty),
		.full   (full)
	);

	kbcc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.empty       (empty),
		.pop         (pop),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.out_char    (out_char),
		.end_of_text (end_of_text)
	);

endmodule

>>> verif/tb_key_base32_checksum_encoder_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_key_base32_checksum_encoder_core
// Self-checking bench for the key base32 checksum encoder. Key records are
// sent byte by byte. A bit-true predictor runs the CRC-16 and the base32
// grouping on every accepted beat and queues the characters it expects.
// Each character beat is checked against that queue. Both sides idle at
// random, the output is once held off long enough to back up the input, and
// the sender twice waits for the text to drain before it goes on.
// ----------------------------------------------------------------------------
module tb_key_base32_checksum_encoder_core import kbcc_pkg::*;;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned TAIL_CYCLES = 20;
	localparam int unsigned LONG_HOLD   = 80;
	localparam int unsigned DIRECTED_N  = 17;
	localparam int unsigned RANDOM_N    = 208;
	localparam logic [6:0]  ASCII_A     = 7'h41;
	localparam logic [6:0]  ASCII_2     = 7'h32;

	typedef struct packed {
		logic [7:0] version;
		logic [7:0] payload;
		logic       is_first;
		logic       is_last;
		logic       drain;
	} key_byte_t;

	typedef struct packed {
		logic [6:0] chr;
		logic       eot;
	} text_beat_t;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       in_valid     = 1'b0;
	logic       in_stall;
	logic [7:0] lead_byte    = 8'h00;
	logic [7:0] payload_byte = 8'h00;
	logic       start_req    = 1'b0;
	logic       final_req    = 1'b0;
	logic       out_valid;
	logic       out_stall    = 1'b0;
	logic [6:0] out_char;
	logic       end_of_text;

	key_byte_t   pending_bytes[$];
	text_beat_t  expected_text[$];
	key_byte_t   next_byte;
	key_byte_t   taken_byte;
	text_beat_t  want;

	logic [15:0] pred_crc    = 16'h0000;
	logic [3:0]  pred_held   = 4'h0;
	int unsigned pred_held_n = 0;

	int unsigned errors      = 0;
	int unsigned bytes_taken = 0;
	int unsigned send_gap    = 0;
	int unsigned send_calm   = 0;
	int unsigned recv_hold   = 0;
	int unsigned recv_calm   = 0;
	int unsigned cycle_count = 0;
	bit          long_hold_done = 1'b0;

	key_base32_checksum_encoder_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.lead_byte    (lead_byte),
		.payload_byte (payload_byte),
		.start_req    (start_req),
		.final_req    (final_req),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_char     (out_char),
		.end_of_text  (end_of_text)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---- predictor -----------------------------------------------------

	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	function automatic logic [6:0] b32_char(input logic [4:0] v);
		return (v < 5'd26) ? ASCII_A + 7'(v) : ASCII_2 + 7'(v - 5'd26);
	endfunction

	task automatic queue_char(input logic [4:0] v);
		text_beat_t tb;
		tb.chr = b32_char(v);
		tb.eot = 1'b0;
		expected_text.push_back(tb);
	endtask

	task automatic shift_in_byte(input logic [7:0] b);
		logic [11:0] acc;
		int unsigned cnt;
		acc = {pred_held, b};
		cnt = pred_held_n + 8;
		while (cnt >= 5) begin
			cnt -= 5;
			queue_char(5'(acc >> cnt));
		end
		pred_held   = 4'(acc & ((12'd1 << cnt) - 12'd1));
		pred_held_n = cnt;
	endtask

	task automatic encode_record_byte(input key_byte_t kb);
		text_beat_t tail;
		if (kb.is_first) begin
			pred_held   = 4'h0;
			pred_held_n = 0;
			pred_crc    = crc16_step(16'h0000, kb.version);
			shift_in_byte(kb.version);
		end
		pred_crc = crc16_step(pred_crc, kb.payload);
		shift_in_byte(kb.payload);
		if (kb.is_last) begin
			shift_in_byte(pred_crc[7:0]);
			shift_in_byte(pred_crc[15:8]);
			if (pred_held_n != 0)
				queue_char(5'({1'b0, pred_held} << (5 - pred_held_n)));
			tail = expected_text.pop_back();
			tail.eot = 1'b1;
			expected_text.push_back(tail);
			pred_crc    = 16'h0000;
			pred_held   = 4'h0;
			pred_held_n = 0;
		end
	endtask

	// ---- stimulus ------------------------------------------------------

	function automatic void queue_key_byte(input logic [7:0] v, input logic [7:0] p,
			input logic s, input logic f, input logic d);
		key_byte_t kb;
		kb.version  = v;
		kb.payload  = p;
		kb.is_first = s;
		kb.is_last  = f;
		kb.drain    = d;
		pending_bytes.push_back(kb);
	endfunction

	function automatic int unsigned next_send_gap();
		int unsigned r;
		if (send_calm != 0) begin
			send_calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			send_calm = $urandom_range(10, 40);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 2);
		if (r < 97)
			return $urandom_range(3, 8);
		return $urandom_range(15, 40);
	endfunction

	// ---- driver --------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				taken_byte = {lead_byte, payload_byte, start_req, final_req, 1'b0};
				encode_record_byte(taken_byte);
				bytes_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (send_gap != 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_bytes.size() != 0 &&
						!(pending_bytes[0].drain && expected_text.size() != 0)) begin
					next_byte = pending_bytes.pop_front();
					in_valid     <= 1'b1;
					lead_byte    <= next_byte.version;
					payload_byte <= next_byte.payload;
					start_req    <= next_byte.is_first;
					final_req    <= next_byte.is_last;
					send_gap = next_send_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---- receiver ------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		int unsigned r;
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_hold = 0;
			recv_calm = 0;
		end else begin
			if (recv_hold == 0 && !long_hold_done && bytes_taken >= 60) begin
				long_hold_done = 1'b1;
				recv_hold = LONG_HOLD;
			end
			if (recv_hold == 0 && recv_calm == 0) begin
				r = $urandom_range(0, 99);
				if (r < 3)
					recv_hold = $urandom_range(8, 30);
				else if (r < 6)
					recv_calm = $urandom_range(10, 40);
				else if (r < 30)
					recv_hold = 1;
			end
			if (recv_hold != 0) begin
				recv_hold--;
				out_stall <= 1'b1;
			end else begin
				if (recv_calm != 0)
					recv_calm--;
				out_stall <= 1'b0;
			end
		end
	end

	// ---- monitor -------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_text.size() == 0) begin
				errors++;
				if (errors <= 40)
					$display("%0t: extra beat, expected none, actual char %h eot %b",
						$time, out_char, end_of_text);
			end else begin
				want = expected_text.pop_front();
				if (out_char !== want.chr) begin
					errors++;
					if (errors <= 40)
						$display("%0t: out_char mismatch, expected %h actual %h",
							$time, want.chr, out_char);
				end
				if (end_of_text !== want.eot) begin
					errors++;
					if (errors <= 40)
						$display("%0t: end_of_text mismatch, expected %b actual %b",
							$time, want.eot, end_of_text);
				end
			end
		end
	end

	// ---- watchdog ------------------------------------------------------

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", CYCLE_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	// ---- main sequence -------------------------------------------------

	initial begin
		int unsigned rec_len;
		int unsigned kind;
		int unsigned broken;
		int unsigned rec_cnt;
		logic        s;
		logic        f;

		// bytes with no start right after reset, version must be ignored
		queue_key_byte(8'hFF, 8'h00, 1'b0, 1'b0, 1'b0);
		queue_key_byte(8'h00, 8'hFF, 1'b0, 1'b1, 1'b0);
		// one-byte records, start and final on the same beat
		queue_key_byte(8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0);
		queue_key_byte(8'h00, 8'h00, 1'b1, 1'b1, 1'b0);
		// ordinary record, version ignored on later bytes
		queue_key_byte(8'h30, 8'h80, 1'b1, 1'b0, 1'b0);
		queue_key_byte(8'hFF, 8'h01, 1'b0, 1'b0, 1'b0);
		queue_key_byte(8'h00, 8'h7F, 1'b0, 1'b0, 1'b0);
		queue_key_byte(8'h55, 8'hAA, 1'b0, 1'b1, 1'b0);
		// unfinished record dropped by a new start
		queue_key_byte(8'h90, 8'h12, 1'b1, 1'b0, 1'b0);
		queue_key_byte(8'h90, 8'h34, 1'b0, 1'b0, 1'b0);
		queue_key_byte(8'hA5, 8'h5A, 1'b1, 1'b0, 1'b0);
		queue_key_byte(8'h5A, 8'hC3, 1'b0, 1'b1, 1'b0);
		// lengths that leave three held bits and none at the flush
		queue_key_byte(8'h01, 8'hFE, 1'b1, 1'b0, 1'b0);
		queue_key_byte(8'h02, 8'hEF, 1'b0, 1'b0, 1'b0);
		queue_key_byte(8'h03, 8'h10, 1'b0, 1'b1, 1'b0);
		queue_key_byte(8'h18, 8'h81, 1'b1, 1'b0, 1'b0);
		queue_key_byte(8'hE7, 8'h66, 1'b0, 1'b1, 1'b0);

		rec_cnt = 0;
		while (pending_bytes.size() < DIRECTED_N + RANDOM_N) begin
			kind = $urandom_range(0, 99);
			if (kind < 15)
				rec_len = 1;
			else if (kind < 40)
				rec_len = 8;
			else if (kind < 46)
				rec_len = 32;
			else
				rec_len = $urandom_range(2, 12);
			broken = $urandom_range(0, 99);
			for (int i = 0; i < rec_len; i++) begin
				s = (i == 0) && broken >= 5;
				f = (i == rec_len - 1) && !(broken >= 5 && broken < 10);
				if (broken >= 10 && broken < 14) begin
					s = 1'($urandom_range(0, 3) == 0);
					f = 1'($urandom_range(0, 3) == 0);
				end
				queue_key_byte(8'($urandom), 8'($urandom), s, f,
					(i == 0) && (rec_cnt == 0 || rec_cnt == 14));
			end
			rec_cnt++;
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		@(posedge clk);
		while (pending_bytes.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_text.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
